// ===== rtl/ggc_pkg.sv =====
// Shared widths, constants and the memory request bundle for the greedy
// graph coloring block. No dependencies.
`default_nettype none

package ggc_pkg;

  localparam int STORE_DEPTH      = 32;
  localparam int ADDR_W           = 5;
  localparam int ROW_W            = 32;
  localparam int COLOR_W          = 6;
  localparam int CNT_W            = 6;
  localparam int TAKEN_W          = 33;
  localparam int DEF_MAX_VERTICES = 32;

  localparam logic [COLOR_W-1:0] FIRST_COLOR = COLOR_W'(1);

  typedef struct packed {
    logic                 adj_we;
    logic [ADDR_W-1:0]    adj_waddr;
    logic [ROW_W-1:0]     adj_wdata;
    logic [ADDR_W-1:0]    adj_raddr;
    logic                 col_we;
    logic [ADDR_W-1:0]    col_waddr;
    logic [COLOR_W-1:0]   col_wdata;
    logic [ADDR_W-1:0]    col_raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/ggc_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
// Depends on ggc_pkg for default sizes.
`default_nettype none

module ggc_ram
  import ggc_pkg::*;
#(
  parameter int W = ROW_W,
  parameter int D = STORE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata_q
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_q <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ggc_seq.sv =====
// Sequencer for load, first-fit coloring and result drain.
// Depends on ggc_pkg; drives the two stores through a mem_req_t bundle.
`default_nettype none

module ggc_seq
  import ggc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ROW_W-1:0]    in_adjacency_row,
  input  wire logic                in_is_last_row,
  output mem_req_t                 req,
  input  wire logic [ROW_W-1:0]    adj_q,
  input  wire logic [COLOR_W-1:0]  col_q,
  output logic                     out_strobe,
  output logic [ADDR_W-1:0]        out_vertex_index,
  output logic [COLOR_W-1:0]       out_vertex_color,
  output logic [COLOR_W-1:0]       out_colors_used,
  output logic                     out_last_result
);

  localparam int ROW_CAP = (MAX_VERTICES < STORE_DEPTH) ? MAX_VERTICES : STORE_DEPTH;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(ROW_CAP);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_ROW   = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_PICK  = 3'd4;
  localparam logic [2:0] ST_OWAIT = 3'd5;
  localparam logic [2:0] ST_OEMIT = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [ADDR_W-1:0]  i_r, i_nxt;
  logic [ADDR_W-1:0]  j_r, j_nxt;
  logic [ADDR_W-1:0]  o_r, o_nxt;
  logic [COLOR_W-1:0] c_r, c_nxt;
  logic [COLOR_W-1:0] top_r, top_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;

  logic               strobe_r, strobe_nxt;
  logic [ADDR_W-1:0]  oidx_r, oidx_nxt;
  logic [COLOR_W-1:0] ocol_r, ocol_nxt;
  logic [COLOR_W-1:0] oused_r, oused_nxt;
  logic               olast_r, olast_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    o_nxt     = o_r;
    c_nxt     = c_r;
    top_nxt   = top_r;
    taken_nxt = taken_r;
    strobe_nxt = 1'b0;
    oidx_nxt  = oidx_r;
    ocol_nxt  = ocol_r;
    oused_nxt = oused_r;
    olast_nxt = olast_r;

    req = '0;
    req.adj_waddr = cnt_r[ADDR_W-1:0];
    req.adj_wdata = in_adjacency_row;
    req.adj_raddr = i_r;
    req.col_waddr = i_r;
    req.col_wdata = c_r;
    req.col_raddr = (state_r == ST_OWAIT) ? o_r : j_r;

    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          req.adj_we = 1'b1;
          cnt_nxt    = cnt_r + CNT_ONE;
          if (in_is_last_row || (cnt_r + CNT_ONE == CAP_C)) begin
            n_nxt     = cnt_r + CNT_ONE;
            cnt_nxt   = '0;
            i_nxt     = '0;
            top_nxt   = '0;
            state_nxt = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        j_nxt     = '0;
        taken_nxt = '0;
        c_nxt     = FIRST_COLOR;
        state_nxt = (i_r == '0) ? ST_PICK : ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (adj_q[j_r]) begin
          taken_nxt[col_q] = 1'b1;
        end
        j_nxt     = j_r + ADDR_ONE;
        state_nxt = (j_r + ADDR_ONE == i_r) ? ST_PICK : ST_WAIT;
      end
      ST_PICK: begin
        if (!taken_r[c_r]) begin
          req.col_we = 1'b1;
          if (c_r > top_r) begin
            top_nxt = c_r;
          end
          if ({1'b0, i_r} + CNT_ONE == n_r) begin
            o_nxt     = '0;
            state_nxt = ST_OWAIT;
          end else begin
            i_nxt     = i_r + ADDR_ONE;
            state_nxt = ST_ROW;
          end
        end else begin
          c_nxt = c_r + COLOR_W'(1);
        end
      end
      ST_OWAIT: begin
        state_nxt = ST_OEMIT;
      end
      ST_OEMIT: begin
        strobe_nxt = 1'b1;
        oidx_nxt   = o_r;
        ocol_nxt   = col_q;
        oused_nxt  = top_r;
        olast_nxt  = ({1'b0, o_r} + CNT_ONE == n_r);
        if ({1'b0, o_r} + CNT_ONE == n_r) begin
          state_nxt = ST_LOAD;
        end else begin
          o_nxt     = o_r + ADDR_ONE;
          state_nxt = ST_OWAIT;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      top_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      top_r    <= top_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    o_r     <= o_nxt;
    c_r     <= c_nxt;
    taken_r <= taken_nxt;
    oidx_r  <= oidx_nxt;
    ocol_r  <= ocol_nxt;
    oused_r <= oused_nxt;
    olast_r <= olast_nxt;
  end

  assign busy             = (state_r != ST_LOAD);
  assign out_strobe       = strobe_r;
  assign out_vertex_index = oidx_r;
  assign out_vertex_color = ocol_r;
  assign out_colors_used  = oused_r;
  assign out_last_result  = olast_r;

endmodule

`default_nettype wire

// ===== rtl/greedy_graph_coloring.sv =====
// Top level of the greedy first-fit graph coloring block.
// Depends on ggc_pkg, ggc_ram and ggc_seq.
//
// Usage:
//   Input words: one adjacency row per word, taken at a rising edge with
//   start high and busy low. in_is_last_row ends the graph; a row that fills
//   the store (MAX_VERTICES rows, at most 32) ends it too. Rows load at one
//   per cycle and cause no result.
//   After the last row busy rises and the vertices are coloured in index
//   order. Vertex i is first set up; then each earlier vertex takes one
//   registered read of the colour store and one accumulate into the
//   taken-colour bitmap; then the free-colour scan tries one colour at a
//   time until it finds one not taken. The shared bitmap and the single
//   colour-store read port make these steps run one after another.
//   Result words: N words, each a colour-store read and then the output
//   register, shown for a single cycle with out_strobe high.
//   out_colors_used carries the highest colour of the whole graph and
//   out_last_result marks the final vertex. The receiver cannot stall.
//   busy falls as the last result is registered, so a new graph may start
//   while that word is still on the ports.
//   Reset: rst_n low, synchronous; clears the row count, the sequencer and
//   the strobe. Store contents are left as they are and never read unwritten.
`default_nettype none

module greedy_graph_coloring
  import ggc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ROW_W-1:0]   in_adjacency_row,
  input  wire logic               in_is_last_row,
  output logic                    out_strobe,
  output logic [ADDR_W-1:0]       out_vertex_index,
  output logic [COLOR_W-1:0]      out_vertex_color,
  output logic [COLOR_W-1:0]      out_colors_used,
  output logic                    out_last_result
);

  mem_req_t           req;
  logic [ROW_W-1:0]   adj_q;
  logic [COLOR_W-1:0] col_q;

  // Adjacency store: written while loading, read at the vertex being coloured.
  ggc_ram #(
    .W (ROW_W),
    .D (STORE_DEPTH)
  ) u_adj (
    .clk     (clk),
    .we      (req.adj_we),
    .waddr   (req.adj_waddr),
    .wdata   (req.adj_wdata),
    .raddr   (req.adj_raddr),
    .rdata_q (adj_q)
  );

  // Colour store: written once per vertex, read per neighbour and on drain.
  ggc_ram #(
    .W (COLOR_W),
    .D (STORE_DEPTH)
  ) u_col (
    .clk     (clk),
    .we      (req.col_we),
    .waddr   (req.col_waddr),
    .wdata   (req.col_wdata),
    .raddr   (req.col_raddr),
    .rdata_q (col_q)
  );

  // Sequencer: load, neighbour scan, free-colour pick and result drain.
  ggc_seq #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_adjacency_row (in_adjacency_row),
    .in_is_last_row   (in_is_last_row),
    .req              (req),
    .adj_q            (adj_q),
    .col_q            (col_q),
    .out_strobe       (out_strobe),
    .out_vertex_index (out_vertex_index),
    .out_vertex_color (out_vertex_color),
    .out_colors_used  (out_colors_used),
    .out_last_result  (out_last_result)
  );

endmodule

`default_nettype wire

// ===== sim/greedy_graph_coloring_tb.sv =====
// Self-checking testbench for greedy_graph_coloring: loads graphs row by row and checks
// every colour word against a first-fit predictor held in the bench.
// Depends on ggc_pkg and the greedy_graph_coloring RTL.
`default_nettype none

module greedy_graph_coloring_tb;
  import ggc_pkg::*;

  localparam int ROW_CAP = (DEF_MAX_VERTICES < STORE_DEPTH) ? DEF_MAX_VERTICES : STORE_DEPTH;
  localparam int RANDOM_ROWS = 500;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DIRECTED_N = 12;

  // One expected result word: the colour of one vertex.
  typedef struct packed {
    logic [ADDR_W-1:0]  vertex;
    logic [COLOR_W-1:0] colour;
    logic [COLOR_W-1:0] used;
    logic               closing;
  } colour_word_t;

  // One line of the directed table. A line may repeat its row; lone_first
  // marks a single-vertex graph whose word is typed in (vertex 0, colour 1).
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic [6:0]       reps;
    logic             lone_first;
  } stim_line_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [ROW_W-1:0]   in_adjacency_row;
  logic               in_is_last_row;
  logic               out_strobe;
  logic [ADDR_W-1:0]  out_vertex_index;
  logic [COLOR_W-1:0] out_vertex_color;
  logic [COLOR_W-1:0] out_colors_used;
  logic               out_last_result;

  // Predictor state: rows of the graph being loaded and the colours found.
  logic [ROW_W-1:0]   adj_rows [STORE_DEPTH];
  logic [COLOR_W-1:0] vertex_colour [STORE_DEPTH];
  int                 rows_held;
  logic [COLOR_W-1:0] graph_top;

  colour_word_t colours_due[$];
  int           errors = 0;
  int           rows_sent = 0;
  int           cycles = 0;

  // Directed graphs: lone vertices, the one-sided adjacency test, a triangle,
  // self loops with bits past the vertex count, and a complete graph that fills
  // the store and ends without a last flag.
  stim_line_t directed_rows [DIRECTED_N] = '{
    '{32'h0000_0000, 1'b1, 7'd1,  1'b1},  // lone vertex, empty row
    '{32'hFFFF_FFFF, 1'b1, 7'd1,  1'b1},  // lone vertex, self loop and stray bits
    '{32'h0000_0002, 1'b0, 7'd1,  1'b0},  // earlier row names vertex 1: ignored
    '{32'h0000_0000, 1'b1, 7'd1,  1'b0},
    '{32'h0000_0000, 1'b0, 7'd1,  1'b0},  // later row names vertex 0: adjacent
    '{32'h0000_0001, 1'b1, 7'd1,  1'b0},
    '{32'h0000_0006, 1'b0, 7'd1,  1'b0},  // triangle
    '{32'h0000_0005, 1'b0, 7'd1,  1'b0},
    '{32'h0000_0003, 1'b1, 7'd1,  1'b0},
    '{32'hFFFF_FFFA, 1'b0, 7'd2,  1'b0},  // self loops, later vertices and bits at or past N only
    '{32'hFFFF_FFFC, 1'b1, 7'd1,  1'b0},
    '{32'hFFFF_FFFF, 1'b0, 7'd32, 1'b0}   // complete graph, store full ends it
  };

  greedy_graph_coloring dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_adjacency_row (in_adjacency_row),
    .in_is_last_row   (in_is_last_row),
    .out_strobe       (out_strobe),
    .out_vertex_index (out_vertex_index),
    .out_vertex_color (out_vertex_color),
    .out_colors_used  (out_colors_used),
    .out_last_result  (out_last_result)
  );

  always #5 clk = ~clk;

  // Store one row; once the graph is complete, colour it first-fit and
  // return the vertex count, else return 0.
  function automatic int load_row(input logic [ROW_W-1:0] row, input logic last_row);
    logic [TAKEN_W-1:0] taken;
    int                 n;
    int                 c;
    if (rows_held >= ROW_CAP) rows_held = 0;
    adj_rows[rows_held] = row;
    rows_held++;
    if (!last_row && rows_held < ROW_CAP) return 0;
    n = rows_held;
    graph_top = '0;
    for (int i = 0; i < n; i++) begin
      // Only earlier vertices count, so self loops and bits past N drop out.
      taken = '0;
      for (int j = 0; j < i; j++)
        if (adj_rows[i][j]) taken[vertex_colour[j]] = 1'b1;
      c = 1;
      while (c < TAKEN_W && taken[c]) c++;
      vertex_colour[i] = COLOR_W'(c);
      if (vertex_colour[i] > graph_top) graph_top = vertex_colour[i];
    end
    rows_held = 0;
    return n;
  endfunction

  // Offer one row and hold it until the block takes it, then queue the words
  // it causes. Afterwards drop start for a random gap when the sender idles.
  task automatic send_row(input logic [ROW_W-1:0] row, input logic last_row,
                          input bit lone_first, input int idle_pct);
    int n;
    start            <= 1'b1;
    in_adjacency_row <= row;
    in_is_last_row   <= last_row;
    do @(posedge clk); while (busy);
    n = load_row(row, last_row);
    if (lone_first)
      colours_due.push_back('{vertex: '0, colour: FIRST_COLOR, used: FIRST_COLOR,
                              closing: 1'b1});
    else
      for (int i = 0; i < n; i++)
        colours_due.push_back('{vertex: ADDR_W'(i), colour: vertex_colour[i],
                                used: graph_top, closing: (i == n - 1)});
    rows_sent++;
    // Decide cycle by cycle whether the sender stays idle.
    while ($urandom_range(99) < idle_pct) begin
      // Scramble the idle payload: the block must ignore it.
      start            <= 1'b0;
      in_adjacency_row <= $urandom;
      in_is_last_row   <= 1'($urandom_range(1));
      @(posedge clk);
    end
  endtask

  // Mix dense, sparse and plain random rows so both small and large colour
  // counts turn up.
  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(4))
      0:       return $urandom & $urandom;
      1:       return $urandom | $urandom;
      2:       return $urandom & $urandom & $urandom;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Send one graph of n rows. A full-store graph flags its last row only at
  // random, so both ways of ending the load occur.
  task automatic send_graph(input int n, input int idle_pct);
    logic last_row;
    for (int r = 0; r < n; r++) begin
      last_row = (r == n - 1) && (n < ROW_CAP || $urandom_range(1) == 1);
      send_row(pick_row(), last_row, 1'b0, idle_pct);
    end
  endtask

  // Check each colour word against the oldest expectation as it goes past.
  always @(posedge clk) begin : check_words
    colour_word_t want;
    if (rst_n && out_strobe) begin
      if (colours_due.size() == 0) begin
        $error("unexpected colour word: vertex %0d colour %0d", out_vertex_index,
               out_vertex_color);
        errors++;
      end else begin
        want = colours_due.pop_front();
        if (out_vertex_index !== want.vertex) begin
          $error("vertex_index: expected %0d, got %0d", want.vertex, out_vertex_index);
          errors++;
        end
        if (out_vertex_color !== want.colour) begin
          $error("vertex_color: expected %0d, got %0d", want.colour, out_vertex_color);
          errors++;
        end
        if (out_colors_used !== want.used) begin
          $error("colors_used: expected %0d, got %0d", want.used, out_colors_used);
          errors++;
        end
        if (out_last_result !== want.closing) begin
          $error("last_result: expected %0d, got %0d", want.closing, out_last_result);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int base;
    int idle_pct;
    int n;
    int pick;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_adjacency_row <= '0;
    in_is_last_row   <= 1'b0;
    rows_held = 0;
    graph_top = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table with the sender always ready.
    for (int k = 0; k < DIRECTED_N; k++)
      for (int r = 0; r < directed_rows[k].reps; r++)
        send_row(directed_rows[k].row, directed_rows[k].last_row,
                 directed_rows[k].lone_first, 0);

    // Random graphs, mostly small, now and then up to a full store; the
    // sender idles hard, then harder, then not at all.
    base = rows_sent;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 32 : (phase == 1) ? 55 : 0;
      while (rows_sent < base + (RANDOM_ROWS * (phase + 1)) / 3) begin
        pick = $urandom_range(99);
        if (pick < 70)      n = $urandom_range(1, 8);
        else if (pick < 90) n = $urandom_range(9, 24);
        else                n = $urandom_range(25, ROW_CAP);
        send_graph(n, idle_pct);
      end
    end

    start <= 1'b0;
    while (colours_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== greedy_graph_coloring.f =====
rtl/ggc_pkg.sv
rtl/ggc_ram.sv
rtl/ggc_seq.sv
rtl/greedy_graph_coloring.sv
sim/greedy_graph_coloring_tb.sv
